>>> rtl/core/plfr_pkg.sv
package plfr_pkg;

    localparam int NUM_PROCS           = 256;
    localparam int MAX_FRAMES_PER_PROC = 8;
    localparam int PAGE_BITS           = 16;

    // widths of the external fields
    localparam int PID_IN_W   = 8;
    localparam int PAGE_IN_W  = 16;
    localparam int SLOT_W     = 11;
    localparam int NEXT_W     = 12;
    localparam int FAULT_W    = 32;
    localparam int FRAMES_W   = 4;
    localparam int CFG_DATA_W = 4;
    localparam int CFG_IDX_W  = 1;

    // derived widths; process count is taken as a power of two
    localparam int PID_W  = $clog2(NUM_PROCS);
    localparam int PAGE_W = (PAGE_BITS < PAGE_IN_W) ? PAGE_BITS : PAGE_IN_W;
    localparam int FILL_W = $clog2(MAX_FRAMES_PER_PROC + 1);
    localparam int IDX_W  = (MAX_FRAMES_PER_PROC > 1) ? $clog2(MAX_FRAMES_PER_PROC) : 1;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b1;

    localparam logic [FRAMES_W-1:0] FRAMES_RESET = 4'd3;
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    typedef struct packed {
        logic [PID_W-1:0]  pid;
        logic [PAGE_W-1:0] page;
    } ref_t;

    typedef struct packed {
        logic [FRAMES_W-1:0] frames;
        logic                policy;
    } cfg_t;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [SLOT_W-1:0] slot;
    } entry_t;

    typedef struct packed {
        entry_t [MAX_FRAMES_PER_PROC-1:0] ent;
        logic [FILL_W-1:0]                fill;
    } row_t;

    typedef enum logic {
        ST_READ,
        ST_EXEC
    } back_state_t;

endpackage

>>> rtl/core/plfr_front.sv
module plfr_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [plfr_pkg::PID_IN_W-1:0]      process_id,
    input  logic [plfr_pkg::PAGE_IN_W-1:0]     page_number,
    output logic                               q_valid,
    output plfr_pkg::ref_t                     q_item,
    input  logic                               q_pop
);

    plfr_pkg::ref_t                    queue_reg [plfr_pkg::QUEUE_DEPTH];
    logic [plfr_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [plfr_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [plfr_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [plfr_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [plfr_pkg::QCNT_W-1:0]       count_reg;
    logic [plfr_pkg::QCNT_W-1:0]       count_next;
    plfr_pkg::ref_t                    in_item;
    logic                              push;
    logic                              pop;

    // classify: wrap process id, keep only the compared page bits
    always_comb
    begin
        in_item.pid  = plfr_pkg::PID_W'(process_id);
        in_item.page = page_number[plfr_pkg::PAGE_W-1:0];
    end

    assign in_ready = (count_reg != plfr_pkg::QCNT_W'(plfr_pkg::QUEUE_DEPTH));
    assign push     = in_valid & in_ready;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop & q_valid;
    assign q_item   = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == plfr_pkg::QPTR_W'(plfr_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == plfr_pkg::QPTR_W'(plfr_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> rtl/core/plfr_back.sv
module plfr_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  plfr_pkg::cfg_t                     cfg,
    input  logic                               q_valid,
    input  plfr_pkg::ref_t                     q_item,
    output logic                               q_pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               hit,
    output logic [plfr_pkg::SLOT_W-1:0]        frame_slot,
    output logic [plfr_pkg::FAULT_W-1:0]       fault_total
);

    localparam int MAXF   = plfr_pkg::MAX_FRAMES_PER_PROC;
    localparam int FILL_W = plfr_pkg::FILL_W;
    localparam int IDX_W  = plfr_pkg::IDX_W;

    // page table rows, one per process; contents undefined until written
    plfr_pkg::row_t                    row_mem [plfr_pkg::NUM_PROCS];
    logic [plfr_pkg::NUM_PROCS-1:0]    row_valid_reg;
    plfr_pkg::row_t                    rd_row_reg;
    logic                              rd_valid_reg;

    plfr_pkg::back_state_t             state_reg;
    plfr_pkg::back_state_t             state_next;

    logic [plfr_pkg::NEXT_W-1:0]       next_free_reg;
    logic [plfr_pkg::NEXT_W-1:0]       next_free_next;
    logic [plfr_pkg::FAULT_W-1:0]      fault_reg;
    logic [plfr_pkg::FAULT_W-1:0]      fault_next;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              out_hit_reg;
    logic [plfr_pkg::SLOT_W-1:0]       out_slot_reg;
    logic [plfr_pkg::FAULT_W-1:0]      out_fault_reg;

    logic                              rd_en;
    logic                              fire;
    logic [FILL_W-1:0]                 row_fill;
    logic [FILL_W-1:0]                 limit;
    logic                              hit_c;
    logic [IDX_W-1:0]                  pos_c;
    logic                              room;
    logic [plfr_pkg::SLOT_W-1:0]       slot_c;
    logic                              shift_en;
    logic [IDX_W-1:0]                  shift_pos;
    plfr_pkg::entry_t                  moved;
    plfr_pkg::row_t                    new_row;

    // sequencer: read row, then compare and write back
    always_comb
    begin
        state_next = state_reg;
        rd_en      = 1'b0;
        fire       = 1'b0;
        case (state_reg)
            plfr_pkg::ST_READ:
            begin
                if (q_valid)
                begin
                    rd_en      = 1'b1;
                    state_next = plfr_pkg::ST_EXEC;
                end
            end
            plfr_pkg::ST_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    fire       = 1'b1;
                    state_next = plfr_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = plfr_pkg::ST_READ;
            end
        endcase
    end

    assign q_pop = fire;

    // frame limit, clamped to 1..MAX
    always_comb
    begin
        if (int'(cfg.frames) > MAXF)
        begin
            limit = FILL_W'(MAXF);
        end
        else if (cfg.frames == '0)
        begin
            limit = FILL_W'(1);
        end
        else
        begin
            limit = FILL_W'(cfg.frames);
        end
    end

    // parallel compare across the row, lowest match wins
    always_comb
    begin
        row_fill = rd_valid_reg ? rd_row_reg.fill : '0;
        if (int'(row_fill) > MAXF)
        begin
            row_fill = FILL_W'(MAXF);
        end
        hit_c = 1'b0;
        pos_c = '0;
        for (int i = MAXF - 1; i >= 0; i--)
        begin
            if ((i < int'(row_fill)) && (rd_row_reg.ent[i].page == q_item.page))
            begin
                hit_c = 1'b1;
                pos_c = IDX_W'(i);
            end
        end
    end

    // row update: append, leave the row as is on a fifo hit, or move one entry to the newest position
    always_comb
    begin
        room      = (row_fill < limit);
        shift_en  = hit_c ? (cfg.policy == plfr_pkg::POLICY_LRU) : !room;
        shift_pos = hit_c ? pos_c : '0;
        if (hit_c)
        begin
            slot_c = rd_row_reg.ent[pos_c].slot;
        end
        else if (room)
        begin
            slot_c = next_free_reg[plfr_pkg::SLOT_W-1:0];
        end
        else
        begin
            slot_c = rd_row_reg.ent[0].slot;
        end
        moved.page = q_item.page;
        moved.slot = slot_c;

        new_row      = rd_row_reg;
        new_row.fill = row_fill;
        if (shift_en)
        begin
            for (int i = 0; i < MAXF; i++)
            begin
                if ((i >= int'(shift_pos)) && (i + 1 < int'(row_fill)))
                begin
                    new_row.ent[i] = rd_row_reg.ent[(i + 1) % MAXF];
                end
                else if (i + 1 == int'(row_fill))
                begin
                    new_row.ent[i] = moved;
                end
            end
        end
        else if (!hit_c)
        begin
            new_row.ent[row_fill[IDX_W-1:0]] = moved;
            new_row.fill = row_fill + 1'b1;
        end

        next_free_next = next_free_reg;
        fault_next     = fault_reg;
        if (fire && !hit_c)
        begin
            fault_next = fault_reg + 1'b1;
            if (room)
            begin
                next_free_next = next_free_reg + 1'b1;
            end
        end

        out_valid_next = (out_valid_reg && !out_ready) || fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= plfr_pkg::ST_READ;
            row_valid_reg <= '0;
            next_free_reg <= '0;
            fault_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                row_valid_reg[q_item.pid] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_row_reg   <= row_mem[q_item.pid];
            rd_valid_reg <= row_valid_reg[q_item.pid];
        end
        if (fire)
        begin
            row_mem[q_item.pid] <= new_row;
            out_hit_reg         <= hit_c;
            out_slot_reg        <= slot_c;
            out_fault_reg       <= fault_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = out_hit_reg;
    assign frame_slot  = out_slot_reg;
    assign fault_total = out_fault_reg;

endmodule

>>> rtl/core/per_process_fifo_lru_page_replacement.sv
// per-process page replacement, local fifo or lru: each item is a (process, page)
// reference and gives one result item with hit, the global frame slot now holding
// the page and the running fault count. the back end takes one item at a time: it
// reads the process's row from the single-port row memory into a register, then
// compares all entries in parallel and writes the row back. a two-entry queue
// after the input lets the front keep taking items while the back end or the
// output register stalls. there is no clearing pass after reset: a valid bit per
// process makes an unwritten row read as empty. the user must write configuration
// (frame limit, policy) only while the block is idle; it does not enforce this.
module per_process_fifo_lru_page_replacement (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write port
    input  logic                                   cfg_we,
    input  logic [plfr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [plfr_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    // reference items
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [plfr_pkg::PID_IN_W-1:0]          process_id,
    input  logic [plfr_pkg::PAGE_IN_W-1:0]         page_number,
    // result items
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   hit,
    output logic [plfr_pkg::SLOT_W-1:0]            frame_slot,
    output logic [plfr_pkg::FAULT_W-1:0]           fault_total
);

    plfr_pkg::cfg_t     cfg_reg;
    plfr_pkg::cfg_t     cfg_next;
    logic               q_valid;
    plfr_pkg::ref_t     q_item;
    logic               q_pop;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                plfr_pkg::CFG_FRAMES:
                begin
                    cfg_next.frames = cfg_wdata[plfr_pkg::FRAMES_W-1:0];
                end
                plfr_pkg::CFG_POLICY:
                begin
                    cfg_next.policy = cfg_wdata[0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frames <= plfr_pkg::FRAMES_RESET;
            cfg_reg.policy <= plfr_pkg::POLICY_FIFO;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: classify and queue incoming items
    plfr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .process_id  (process_id),
        .page_number (page_number),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    // back: row lookup, replacement and result register
    plfr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .frame_slot  (frame_slot),
        .fault_total (fault_total)
    );

endmodule

>>> bench/page_ref_checker.sv
module page_ref_checker
    import plfr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [PID_IN_W-1:0]   process_id,
    input  logic [PAGE_IN_W-1:0]  page_number,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  hit,
    input  logic [SLOT_W-1:0]     frame_slot,
    input  logic [FAULT_W-1:0]    fault_total,
    output int                    pending,
    output int                    failures
);

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic [FAULT_W-1:0] faults;
    } lookup_t;

    // ring of predicted results, far deeper than the block can hold in flight
    localparam int DUE_DEPTH = 64;

    // resident pages per process, oldest first
    logic [PAGE_W-1:0]   res_page [NUM_PROCS][MAX_FRAMES_PER_PROC];
    logic [SLOT_W-1:0]   res_slot [NUM_PROCS][MAX_FRAMES_PER_PROC];
    logic [FILL_W-1:0]   res_fill [NUM_PROCS];
    logic [NEXT_W-1:0]   next_slot;
    logic [FAULT_W-1:0]  fault_count;
    logic [FRAMES_W-1:0] frame_limit_reg;
    logic                policy_reg;

    lookup_t due_buf [DUE_DEPTH];
    int      due_head;
    int      due_tail;
    int      fail_count = 0;

    assign failures = fail_count;

    function automatic void promote(int unsigned pid, int unsigned fill, int unsigned pos);
        logic [PAGE_W-1:0] pg;
        logic [SLOT_W-1:0] sl;
        pg = res_page[pid][pos];
        sl = res_slot[pid][pos];
        for (int unsigned i = pos; i + 1 < fill; i++)
        begin
            res_page[pid][i] = res_page[pid][i+1];
            res_slot[pid][i] = res_slot[pid][i+1];
        end
        res_page[pid][fill-1] = pg;
        res_slot[pid][fill-1] = sl;
    endfunction

    function automatic lookup_t lookup_page(logic [PID_IN_W-1:0] pid_in,
                                            logic [PAGE_IN_W-1:0] page_in);
        int unsigned       pid;
        int unsigned       fill;
        int unsigned       cap;
        int unsigned       pos;
        bit                found;
        logic [PAGE_W-1:0] pg;
        lookup_t           r;
        pid  = pid_in % NUM_PROCS;
        pg   = page_in[PAGE_W-1:0];
        fill = res_fill[pid];
        if (fill > MAX_FRAMES_PER_PROC)
            fill = MAX_FRAMES_PER_PROC;
        cap = frame_limit_reg;
        if (cap < 1)
            cap = 1;
        if (cap > MAX_FRAMES_PER_PROC)
            cap = MAX_FRAMES_PER_PROC;
        found = 1'b0;
        pos   = 0;
        for (int unsigned i = 0; i < fill; i++)
        begin
            if (!found && res_page[pid][i] == pg)
            begin
                found = 1'b1;
                pos   = i;
            end
        end
        r.hit = found;
        if (found)
        begin
            r.slot = res_slot[pid][pos];
            if (policy_reg == POLICY_LRU)
                promote(pid, fill, pos);
        end
        else
        begin
            fault_count = fault_count + 1'b1;
            if (fill < cap)
            begin
                r.slot             = next_slot[SLOT_W-1:0];
                next_slot          = next_slot + 1'b1;
                res_page[pid][fill] = pg;
                res_slot[pid][fill] = r.slot;
                res_fill[pid]      = FILL_W'(fill + 1);
            end
            else
            begin
                // oldest entry gives up its slot and becomes the newest
                r.slot          = res_slot[pid][0];
                res_page[pid][0] = pg;
                promote(pid, fill, 0);
            end
        end
        r.faults = fault_count;
        return r;
    endfunction

    function automatic void report(string field, longint unsigned want, longint unsigned got);
        fail_count++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        lookup_t want;
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PROCS; p++)
                res_fill[p] = '0;
            next_slot       = '0;
            fault_count     = '0;
            frame_limit_reg = FRAMES_RESET;
            policy_reg      = POLICY_FIFO;
            due_head        = 0;
            due_tail        = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_FRAMES)
                    frame_limit_reg = cfg_wdata[FRAMES_W-1:0];
                else
                    policy_reg = cfg_wdata[0];
            end
            if (out_valid && out_ready)
            begin
                if (due_tail == due_head)
                begin
                    fail_count++;
                    $display("%0t: unexpected result item, expected none, %s %0b %0d %0d",
                             $time, "got hit slot faults", hit, frame_slot, fault_total);
                end
                else
                begin
                    want = due_buf[due_head % DUE_DEPTH];
                    due_head++;
                    if (hit !== want.hit)
                        report("hit", want.hit, hit);
                    if (frame_slot !== want.slot)
                        report("frame_slot", want.slot, frame_slot);
                    if (fault_total !== want.faults)
                        report("fault_total", want.faults, fault_total);
                end
            end
            if (in_valid && in_ready)
            begin
                due_buf[due_tail % DUE_DEPTH] = lookup_page(process_id, page_number);
                due_tail++;
            end
            pending <= due_tail - due_head;
        end
    end

endmodule

>>> bench/tb.sv
module tb;
    import plfr_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_ready;
    logic [PID_IN_W-1:0]   process_id;
    logic [PAGE_IN_W-1:0]  page_number;
    logic                  out_valid;
    logic                  out_ready;
    logic                  hit;
    logic [SLOT_W-1:0]     frame_slot;
    logic [FAULT_W-1:0]    fault_total;

    int pending;
    int failures;

    // sender runs without gaps while this is set
    bit steady_send;
    // process pool for the well-formed random references, kept across some phases
    logic [PID_IN_W-1:0] pid_base;

    per_process_fifo_lru_page_replacement dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .process_id  (process_id),
        .page_number (page_number),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .frame_slot  (frame_slot),
        .fault_total (fault_total)
    );

    page_ref_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .process_id  (process_id),
        .page_number (page_number),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .frame_slot  (frame_slot),
        .fault_total (fault_total),
        .pending     (pending),
        .failures    (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // generous fixed limit, far beyond the slowest correct run
    initial
    begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

    // one reference item: optional gap, then hold valid until taken
    // valid is only lowered when a gap follows, so back-to-back items keep it high
    task automatic send_ref(input logic [PID_IN_W-1:0] pid, input logic [PAGE_IN_W-1:0] pg);
        int gap;
        gap = steady_send ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        process_id  <= pid;
        page_number <= pg;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // stop sending and let every outstanding result come back, plus a little slack
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // both registers in two consecutive writes; only called while idle
    task automatic set_mode(input logic [CFG_DATA_W-1:0] frames,
                            input logic [CFG_DATA_W-1:0] policy_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FRAMES;
        cfg_wdata <= frames;
        @(posedge clk);
        cfg_index <= CFG_POLICY;
        cfg_wdata <= policy_word;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly a small pool of processes cycling over a small page window,
    // so hits, fills and replacements all happen; the rest is full-range noise
    task automatic run_phase(input int count);
        logic [PAGE_IN_W-1:0] page_base;
        int                   span;
        if ($urandom_range(0, 1) == 0)
            pid_base = PID_IN_W'($urandom);
        page_base   = PAGE_IN_W'($urandom);
        span        = $urandom_range(2, 12);
        steady_send = ($urandom_range(0, 3) == 0);
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 85)
                send_ref(pid_base + PID_IN_W'($urandom_range(0, 3)),
                         page_base + PAGE_IN_W'($urandom_range(0, span)));
            else
                send_ref(PID_IN_W'($urandom), PAGE_IN_W'($urandom));
        end
    endtask

    // result side: per-item stall, with occasional runs of no stalling at all
    initial
    begin
        int stall;
        int taken;
        bit steady_take;
        out_ready   = 1'b0;
        taken       = 0;
        steady_take = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (taken % 50 == 0)
                steady_take = ($urandom_range(0, 3) == 0);
            stall = steady_take ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
        end
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] frame_plan [12];
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_FRAMES;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        process_id  = '0;
        page_number = '0;
        steady_send = 1'b0;
        pid_base    = '0;
        frame_plan  = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd4, 4'd2,
                        4'd7, 4'd3, 4'd5, 4'd6, 4'd8, 4'd1};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: three frames, fifo
        send_ref(8'd0, 16'h0000);       // first fault, slot 0
        send_ref(8'd0, 16'h0000);       // hit
        send_ref(8'd255, 16'hFFFF);     // top process, top page
        send_ref(8'd255, 16'hFFFF);
        send_ref(8'd0, 16'h0001);
        send_ref(8'd0, 16'h0002);       // process 0 now full
        send_ref(8'd0, 16'h0000);       // fifo hit leaves the order alone
        send_ref(8'd0, 16'h0003);       // evicts page 0 despite the recent hit
        send_ref(8'd1, 16'h8000);       // top page bit distinguishes these two
        send_ref(8'd1, 16'h0000);
        wait_idle();

        // lru: a hit refreshes the page, so the next fault evicts another one
        set_mode(4'd3, {3'b000, POLICY_LRU});
        send_ref(8'd2, 16'd10);
        send_ref(8'd2, 16'd11);
        send_ref(8'd2, 16'd12);
        send_ref(8'd2, 16'd10);
        send_ref(8'd2, 16'd13);         // evicts 11, not 10
        send_ref(8'd2, 16'd10);
        wait_idle();

        // zero frames acts as one; process 2 keeps its three pages after lowering
        set_mode(4'd0, {3'b111, POLICY_LRU});
        send_ref(8'd3, 16'd5);
        send_ref(8'd3, 16'd6);
        send_ref(8'd3, 16'd5);
        send_ref(8'd2, 16'd14);         // replaces oldest, fill stays at three
        send_ref(8'd2, 16'd10);
        wait_idle();

        // random phases, each pause also drains every outstanding result
        foreach (frame_plan[i])
        begin
            set_mode(frame_plan[i], {(CFG_DATA_W-1)'($urandom), 1'(i % 2)});
            run_phase(136);
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> per_process_fifo_lru_page_replacement.f
rtl/core/plfr_pkg.sv
rtl/core/plfr_front.sv
rtl/core/plfr_back.sv
rtl/core/per_process_fifo_lru_page_replacement.sv
bench/page_ref_checker.sv
bench/tb.sv
